[rtl/cpmt_pkg.sv]
// Package for the CAN PDU mapping table: field widths, request and status codes,
// and the search token that travels along the row of table cells.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package cpmt_pkg;

  // Payload field widths.
  localparam int unsigned PduW = 16;
  localparam int unsigned CtlW = 3;
  localparam int unsigned CidW = 32;
  localparam int unsigned OpW  = 3;
  localparam int unsigned StW  = 2;

  // Request opcodes.
  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD_RX = 3'd1,
    OP_ADD_TX = 3'd2,
    OP_RX_PDU = 3'd3,
    OP_TX_PDU = 3'd4,
    OP_RX_CID = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [StW-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Control states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_e;

  // Search token handed from cell to cell, carrying the key and the first hit.
  typedef struct packed {
    logic            active;
    logic            use_tx;
    logic            by_cid;
    logic [PduW-1:0] pdu;
    logic [CtlW-1:0] ctl;
    logic [CidW-1:0] cid;
    logic            hit;
    logic [PduW-1:0] hit_pdu;
    logic [CtlW-1:0] hit_ctl;
    logic [CidW-1:0] hit_cid;
  } token_t;

  // Append request broadcast to all cells.
  typedef struct packed {
    logic            rx_en;
    logic            tx_en;
    logic [PduW-1:0] pdu;
    logic [CtlW-1:0] ctl;
    logic [CidW-1:0] cid;
  } wr_t;

endpackage

`default_nettype wire

[rtl/cpmt_cell.sv]
// One cell of the mapping table row: holds one receive and one transmit entry,
// compares them against the passing search token and registers it onward.
// Depends on cpmt_pkg.
`default_nettype none

module cpmt_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CntW = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CntW-1:0]   rx_cnt_i,
  input  wire logic [CntW-1:0]   tx_cnt_i,
  input  wire cpmt_pkg::wr_t     wr_i,
  input  wire cpmt_pkg::token_t  tok_i,
  output cpmt_pkg::token_t       tok_o
);

  localparam logic [CntW-1:0] MyIdx = CntW'(IDX);

  logic [cpmt_pkg::PduW-1:0] rx_pdu_q, tx_pdu_q;
  logic [cpmt_pkg::CtlW-1:0] rx_ctl_q, tx_ctl_q;
  logic [cpmt_pkg::CidW-1:0] rx_cid_q, tx_cid_q;
  logic                      rx_live, tx_live, match;
  cpmt_pkg::token_t          tok_d, tok_q;

  // Entry storage; an entry is written when the table's fill count points here.
  always_ff @(posedge clk_i) begin
    if (wr_i.rx_en && (rx_cnt_i == MyIdx)) begin
      rx_pdu_q <= wr_i.pdu;
      rx_ctl_q <= wr_i.ctl;
      rx_cid_q <= wr_i.cid;
    end
    if (wr_i.tx_en && (tx_cnt_i == MyIdx)) begin
      tx_pdu_q <= wr_i.pdu;
      tx_ctl_q <= wr_i.ctl;
      tx_cid_q <= wr_i.cid;
    end
  end

  // Only entries below the fill count take part in a search.
  assign rx_live = (MyIdx < rx_cnt_i);
  assign tx_live = (MyIdx < tx_cnt_i);

  always_comb begin
    if (tok_i.use_tx) begin
      match = tx_live && (tx_pdu_q == tok_i.pdu);
    end else if (tok_i.by_cid) begin
      match = rx_live && (rx_ctl_q == tok_i.ctl) && (rx_cid_q == tok_i.cid);
    end else begin
      match = rx_live && (rx_pdu_q == tok_i.pdu);
    end
  end

  // The first hit along the row is latched into the token and kept.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.active && !tok_i.hit && match) begin
      tok_d.hit = 1'b1;
      if (tok_i.use_tx) begin
        tok_d.hit_pdu = tx_pdu_q;
        tok_d.hit_ctl = tx_ctl_q;
        tok_d.hit_cid = tx_cid_q;
      end else begin
        tok_d.hit_pdu = rx_pdu_q;
        tok_d.hit_ctl = rx_ctl_q;
        tok_d.hit_cid = rx_cid_q;
      end
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[rtl/can_pdu_mapping_table.sv]
// CAN PDU mapping table.
//
// Keeps an append-only receive table and transmit table, each of TABLE_DEPTH
// entries mapping a PDU id to a controller and a CAN identifier. Requests come
// in on a valid/ready channel (opcode, pdu_id, controller, can_id): clear both
// tables, append to one table, or look up an entry. Each request yields exactly
// one result on a valid/ready output channel (status and the matched entry).
//
// Entries sit in a row of TABLE_DEPTH cells. A lookup launches a token that
// moves one cell per cycle, picks up the earliest matching entry and passes
// the launch register, the cells, the result stage and the output register.
// Appends, clears and undefined opcodes pass the result stage and the output
// register. One request is handled at a time; the next is accepted once the
// previous result is in the output register, even while it waits to be taken.
//
// Reset empties both tables by zeroing the fill counts; no clearing pass runs.
// When the receiver stalls, the result holds in the output register and a
// finished result behind it waits in the result stage, blocking new requests.
//
// Depends on cpmt_pkg and cpmt_cell.
`default_nettype none

module can_pdu_mapping_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [cpmt_pkg::OpW-1:0]  opcode_i,
  input  wire logic [cpmt_pkg::PduW-1:0] pdu_id_i,
  input  wire logic [cpmt_pkg::CtlW-1:0] controller_i,
  input  wire logic [cpmt_pkg::CidW-1:0] can_id_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [cpmt_pkg::StW-1:0]       status_o,
  output logic [cpmt_pkg::PduW-1:0]      found_pdu_id_o,
  output logic [cpmt_pkg::CtlW-1:0]      found_controller_o,
  output logic [cpmt_pkg::CidW-1:0]      found_can_id_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(TABLE_DEPTH);

  cpmt_pkg::state_e state_q, state_d;
  cpmt_pkg::op_e    op;
  cpmt_pkg::token_t tok [TABLE_DEPTH+1];
  cpmt_pkg::token_t tok0_d, tok0_q;
  cpmt_pkg::wr_t    wr;

  logic [CntW-1:0] rx_cnt_q, rx_cnt_d, tx_cnt_q, tx_cnt_d;
  logic            accept, is_search, rx_full, tx_full;
  logic            load_imm, load_srch, out_load;
  logic            search_done;

  logic [cpmt_pkg::StW-1:0]  imm_status;
  logic [cpmt_pkg::StW-1:0]  res_status_q, res_status_d;
  logic [cpmt_pkg::PduW-1:0] res_pdu_q, res_pdu_d;
  logic [cpmt_pkg::CtlW-1:0] res_ctl_q, res_ctl_d;
  logic [cpmt_pkg::CidW-1:0] res_cid_q, res_cid_d;
  logic                      out_valid_q, out_valid_d;

  assign op          = cpmt_pkg::op_e'(opcode_i);
  assign accept      = in_valid_i && in_ready_o;
  assign rx_full     = (rx_cnt_q == Full);
  assign tx_full     = (tx_cnt_q == Full);
  assign search_done = tok[TABLE_DEPTH].active;

  // Request decode: lookups go down the row, everything else answers at once.
  always_comb begin
    is_search  = 1'b0;
    imm_status = cpmt_pkg::ST_OK;
    unique case (op)
      cpmt_pkg::OP_CLEAR:  imm_status = cpmt_pkg::ST_OK;
      cpmt_pkg::OP_ADD_RX: imm_status = rx_full ? cpmt_pkg::ST_FULL : cpmt_pkg::ST_OK;
      cpmt_pkg::OP_ADD_TX: imm_status = tx_full ? cpmt_pkg::ST_FULL : cpmt_pkg::ST_OK;
      cpmt_pkg::OP_RX_PDU,
      cpmt_pkg::OP_TX_PDU,
      cpmt_pkg::OP_RX_CID: is_search = 1'b1;
      default:             imm_status = cpmt_pkg::ST_MISS;
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpmt_pkg::S_IDLE: begin
        if (accept) begin
          state_d = is_search ? cpmt_pkg::S_SEARCH : cpmt_pkg::S_RESULT;
        end
      end
      cpmt_pkg::S_SEARCH: begin
        if (search_done) begin
          state_d = cpmt_pkg::S_RESULT;
        end
      end
      cpmt_pkg::S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = cpmt_pkg::S_IDLE;
        end
      end
      default: state_d = cpmt_pkg::S_IDLE;
    endcase
  end

  // State-driven control outputs.
  always_comb begin
    in_ready_o = 1'b0;
    load_imm   = 1'b0;
    load_srch  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      cpmt_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        load_imm   = accept && !is_search;
      end
      cpmt_pkg::S_SEARCH: load_srch = search_done;
      cpmt_pkg::S_RESULT: out_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Fill counts and the append request broadcast to the cells.
  always_comb begin
    wr.rx_en = accept && (op == cpmt_pkg::OP_ADD_RX) && !rx_full;
    wr.tx_en = accept && (op == cpmt_pkg::OP_ADD_TX) && !tx_full;
    wr.pdu   = pdu_id_i;
    wr.ctl   = controller_i;
    wr.cid   = can_id_i;

    rx_cnt_d = rx_cnt_q;
    tx_cnt_d = tx_cnt_q;
    if (accept && (op == cpmt_pkg::OP_CLEAR)) begin
      rx_cnt_d = '0;
      tx_cnt_d = '0;
    end
    if (wr.rx_en) begin
      rx_cnt_d = rx_cnt_q + CntW'(1);
    end
    if (wr.tx_en) begin
      tx_cnt_d = tx_cnt_q + CntW'(1);
    end
  end

  // Launch token for cell 0; active for a single cycle per lookup.
  always_comb begin
    tok0_d         = tok0_q;
    tok0_d.active  = accept && is_search;
    tok0_d.use_tx  = (op == cpmt_pkg::OP_TX_PDU);
    tok0_d.by_cid  = (op == cpmt_pkg::OP_RX_CID);
    tok0_d.pdu     = pdu_id_i;
    tok0_d.ctl     = controller_i;
    tok0_d.cid     = can_id_i;
    tok0_d.hit     = 1'b0;
    tok0_d.hit_pdu = '0;
    tok0_d.hit_ctl = '0;
    tok0_d.hit_cid = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
    end
  end

  assign tok[0] = tok0_q;

  // The row of table cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cpmt_cell #(
      .IDX  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .rx_cnt_i (rx_cnt_q),
      .tx_cnt_i (tx_cnt_q),
      .wr_i     (wr),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1])
    );
  end

  // Result stage: immediate answers or the token leaving the last cell.
  always_comb begin
    res_status_d = res_status_q;
    res_pdu_d    = res_pdu_q;
    res_ctl_d    = res_ctl_q;
    res_cid_d    = res_cid_q;
    if (load_imm) begin
      res_status_d = imm_status;
      res_pdu_d    = '0;
      res_ctl_d    = '0;
      res_cid_d    = '0;
    end else if (load_srch) begin
      if (tok[TABLE_DEPTH].hit) begin
        res_status_d = cpmt_pkg::ST_OK;
        res_pdu_d    = tok[TABLE_DEPTH].hit_pdu;
        res_ctl_d    = tok[TABLE_DEPTH].hit_ctl;
        res_cid_d    = tok[TABLE_DEPTH].hit_cid;
      end else begin
        res_status_d = cpmt_pkg::ST_MISS;
        res_pdu_d    = '0;
        res_ctl_d    = '0;
        res_cid_d    = '0;
      end
    end
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpmt_pkg::S_IDLE;
      rx_cnt_q    <= '0;
      tx_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rx_cnt_q    <= rx_cnt_d;
      tx_cnt_q    <= tx_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_pdu_q    <= res_pdu_d;
    res_ctl_q    <= res_ctl_d;
    res_cid_q    <= res_cid_d;
    if (out_load) begin
      status_o           <= res_status_q;
      found_pdu_id_o     <= res_pdu_q;
      found_controller_o <= res_ctl_q;
      found_can_id_o     <= res_cid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/cpmt_checker.sv]
// Port-level checker for the CAN PDU mapping table, bound to the top level.
// Depends on cpmt_pkg and can_pdu_mapping_table.
`default_nettype none

module cpmt_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [cpmt_pkg::StW-1:0]  status_o,
  input wire logic [cpmt_pkg::PduW-1:0] found_pdu_id_o,
  input wire logic [cpmt_pkg::CtlW-1:0] found_controller_o,
  input wire logic [cpmt_pkg::CidW-1:0] found_can_id_o
);

  // A stalled result holds its valid, status, PDU id and CAN id.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(found_pdu_id_o) && $stable(found_can_id_o))
    else $error("stalled result changed");

  // One request at a time: right after an accepted request the block is busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in flight");

  // Anything but a hit carries zero entry fields.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != cpmt_pkg::ST_OK) |->
      (found_pdu_id_o == '0) && (found_controller_o == '0) && (found_can_id_o == '0))
    else $error("non-hit result carries entry data");

  // The status code is always one of the defined codes.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == cpmt_pkg::ST_OK) || (status_o == cpmt_pkg::ST_FULL)
      || (status_o == cpmt_pkg::ST_MISS))
    else $error("undefined status code");

endmodule

bind can_pdu_mapping_table cpmt_checker u_cpmt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .status_o           (status_o),
  .found_pdu_id_o     (found_pdu_id_o),
  .found_controller_o (found_controller_o),
  .found_can_id_o     (found_can_id_o)
);

`default_nettype wire
